/* hdl/stc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants for the slot table free list
// Sizes of the slot table and the cell chain, beat formats, operation and
// status codes.
// ----------------------------------------------------------------------------
package stc_pkg;

   // table geometry
   localparam int CAPACITY    = 256;
   localparam int HANDLE_BITS = 48;
   localparam int CELL_SLOTS  = 32;
   localparam int NUM_CELLS   = CAPACITY / CELL_SLOTS;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int LOC_W = $clog2(CELL_SLOTS);
   localparam int CID_W = IDX_W - LOC_W;
   localparam int CNT_W = IDX_W + 1;

   // free-list link word: index*2+1, or all ones when the list is empty
   localparam int                LINK_W     = 10;
   localparam logic [LINK_W-1:0] EMPTY_LINK = '1;

   // payload field widths
   localparam int OP_W    = 2;
   localparam int SLOT_W  = 8;
   localparam int VALUE_W = 48;
   localparam int STS_W   = 3;

   typedef enum logic [OP_W-1:0] {
      OP_ADD          = 2'd0,
      OP_REMOVE_VALUE = 2'd1,
      OP_REMOVE_INDEX = 2'd2,
      OP_GET          = 2'd3
   } stc_op_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK        = 3'd0,
      STS_FULL      = 3'd1,
      STS_NOT_FOUND = 3'd2,
      STS_BAD       = 3'd3,
      STS_ODD       = 3'd4,
      STS_FREE      = 3'd5
   } stc_status_type;

   // work carried down the cell chain
   typedef enum logic [2:0] {
      CMD_NONE   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_APPEND = 3'd2,
      CMD_RMV    = 3'd3,
      CMD_RMI    = 3'd4,
      CMD_GET    = 3'd5
   } stc_cmd_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_BUSY = 1'b1
   } stc_state_type;

   typedef struct packed {
      stc_op_type         operation;
      logic [SLOT_W-1:0]  slot_index;
      logic [VALUE_W-1:0] item_value;
   } stc_req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  result_index;
      logic [VALUE_W-1:0] result_value;
      stc_status_type     status;
   } stc_rsp_type;

   typedef struct packed {
      logic                   valid;
      stc_cmd_type            cmd;
      logic [IDX_W-1:0]       index;      // target slot, result index on exit
      logic [HANDLE_BITS-1:0] value;      // handle to store or match
      logic [HANDLE_BITS-1:0] link;       // word written into a freed slot
      logic [HANDLE_BITS-1:0] next_link;  // word found in a popped slot
      logic [HANDLE_BITS-1:0] res_value;
      stc_status_type         status;
      logic                   done;       // slot freed by this beat
   } stc_beat_type;

endpackage

/* hdl/stc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_cell: one bank of slots in the chain
// Holds CELL_SLOTS slot words, acts on the beat passing through and hands it
// to the next cell through its output register.
// ----------------------------------------------------------------------------
module stc_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [stc_pkg::CID_W-1:0]     cell_id,
   input  logic [stc_pkg::CNT_W-1:0]     fill_count,
   input  stc_pkg::stc_beat_type         up_beat,
   output stc_pkg::stc_beat_type         down_beat
);

   logic [stc_pkg::HANDLE_BITS-1:0] bank_ff [stc_pkg::CELL_SLOTS];
   stc_pkg::stc_beat_type           beat_ff;
   stc_pkg::stc_beat_type           beat_in;

   logic                            own;
   logic [stc_pkg::LOC_W-1:0]       loc;
   logic [stc_pkg::HANDLE_BITS-1:0] word;
   logic [stc_pkg::CELL_SLOTS-1:0]  hit;
   logic                            any_hit;
   logic [stc_pkg::LOC_W-1:0]       hit_loc;

   logic                            wr_en;
   logic [stc_pkg::LOC_W-1:0]       wr_loc;
   logic [stc_pkg::HANDLE_BITS-1:0] wr_data;

   assign own  = (up_beat.index[stc_pkg::IDX_W-1:stc_pkg::LOC_W] == cell_id);
   assign loc  = up_beat.index[stc_pkg::LOC_W-1:0];
   assign word = bank_ff[loc];

   // live slots in range that hold the handle; lowest one wins
   always_comb begin
      for (int j = 0; j < stc_pkg::CELL_SLOTS; j++) begin
         hit[j] = (bank_ff[j] == up_beat.value) &&
                  ({1'b0, cell_id, (stc_pkg::LOC_W)'(j)} < fill_count);
      end
   end

   always_comb begin
      any_hit = 1'b0;
      hit_loc = '0;
      for (int j = stc_pkg::CELL_SLOTS - 1; j >= 0; j--) begin
         if (hit[j]) begin
            any_hit = 1'b1;
            hit_loc = (stc_pkg::LOC_W)'(j);
         end
      end
   end

   always_comb begin
      beat_in = up_beat;
      wr_en   = 1'b0;
      wr_loc  = loc;
      wr_data = up_beat.value;
      if (up_beat.valid) begin
         case (up_beat.cmd)
            stc_pkg::CMD_POP: begin
               if (own) begin
                  beat_in.next_link = word;
                  wr_en             = 1'b1;
               end
            end
            stc_pkg::CMD_APPEND: begin
               if (own) begin
                  wr_en = 1'b1;
               end
            end
            stc_pkg::CMD_RMI: begin
               if (own) begin
                  if (word[0]) begin
                     beat_in.status = stc_pkg::STS_FREE;
                  end else if (word != up_beat.value) begin
                     beat_in.status = stc_pkg::STS_BAD;
                  end else begin
                     wr_en        = 1'b1;
                     wr_data      = up_beat.link;
                     beat_in.done = 1'b1;
                  end
               end
            end
            stc_pkg::CMD_GET: begin
               if (own) begin
                  beat_in.res_value = word;
                  if (word[0]) begin
                     beat_in.status = stc_pkg::STS_FREE;
                  end
               end
            end
            stc_pkg::CMD_RMV: begin
               if (!up_beat.done && any_hit) begin
                  wr_en          = 1'b1;
                  wr_loc         = hit_loc;
                  wr_data        = up_beat.link;
                  beat_in.done   = 1'b1;
                  beat_in.index  = {cell_id, hit_loc};
                  beat_in.status = stc_pkg::STS_OK;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank_ff[wr_loc] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else begin
         beat_ff <= beat_in;
      end
   end

   assign down_beat = beat_ff;

endmodule

/* hdl/stc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_ctrl: request decode, free-list head, fill count and result buffering
// Launches one beat into the cell chain, commits the state change when it
// returns and buffers the result in an output register plus a skid entry.
// ----------------------------------------------------------------------------
module stc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  stc_pkg::stc_req_type      req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output stc_pkg::stc_rsp_type      rsp_payload,
   output stc_pkg::stc_beat_type     launch_beat,
   output logic [stc_pkg::CNT_W-1:0] fill_count,
   input  stc_pkg::stc_beat_type     done_beat
);

   stc_pkg::stc_state_type         state_ff, state_in;
   logic [stc_pkg::CNT_W-1:0]      fill_ff, fill_in;
   logic [stc_pkg::LINK_W-1:0]     head_ff, head_in;
   stc_pkg::stc_rsp_type           rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   stc_pkg::stc_rsp_type           skid_ff, skid_in;
   logic                           skid_valid_ff, skid_valid_in;

   logic                           accept;
   logic                           odd;
   logic                           in_range;
   logic                           head_ok;
   logic                           next_ok;
   logic                           rsp_fire;
   stc_pkg::stc_rsp_type           done_rsp;

   // ---- state machine ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stc_pkg::CTL_IDLE: begin
            if (accept) begin
               state_in = stc_pkg::CTL_BUSY;
            end
         end
         stc_pkg::CTL_BUSY: begin
            if (done_beat.valid) begin
               state_in = stc_pkg::CTL_IDLE;
            end
         end
         default: begin
            state_in = stc_pkg::CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      case (state_ff)
         stc_pkg::CTL_IDLE: req_stall = skid_valid_ff;
         stc_pkg::CTL_BUSY: req_stall = 1'b1;
         default:           req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   // ---- request decode ----
   assign odd      = req_payload.item_value[0];
   assign in_range = ({1'b0, req_payload.slot_index} < fill_ff);
   assign head_ok  = (head_ff != stc_pkg::EMPTY_LINK) && head_ff[0] &&
                     (head_ff[stc_pkg::LINK_W-1:1] < fill_ff);

   always_comb begin
      launch_beat        = '0;
      launch_beat.valid  = accept;
      launch_beat.cmd    = stc_pkg::CMD_NONE;
      launch_beat.value  = (stc_pkg::HANDLE_BITS)'(req_payload.item_value);
      launch_beat.link   = (stc_pkg::HANDLE_BITS)'(head_ff);
      launch_beat.status = stc_pkg::STS_OK;
      case (req_payload.operation)
         stc_pkg::OP_ADD: begin
            if (odd) begin
               launch_beat.status = stc_pkg::STS_ODD;
            end else if (head_ok) begin
               launch_beat.cmd   = stc_pkg::CMD_POP;
               launch_beat.index = head_ff[stc_pkg::IDX_W:1];
            end else if (fill_ff < (stc_pkg::CNT_W)'(stc_pkg::CAPACITY)) begin
               launch_beat.cmd   = stc_pkg::CMD_APPEND;
               launch_beat.index = fill_ff[stc_pkg::IDX_W-1:0];
            end else begin
               launch_beat.status = stc_pkg::STS_FULL;
            end
         end
         stc_pkg::OP_REMOVE_VALUE: begin
            if (odd) begin
               launch_beat.status = stc_pkg::STS_ODD;
            end else begin
               launch_beat.cmd    = stc_pkg::CMD_RMV;
               launch_beat.status = stc_pkg::STS_NOT_FOUND;
            end
         end
         stc_pkg::OP_REMOVE_INDEX: begin
            launch_beat.index = (stc_pkg::IDX_W)'(req_payload.slot_index);
            if (odd) begin
               launch_beat.status = stc_pkg::STS_ODD;
            end else if (!in_range) begin
               launch_beat.status = stc_pkg::STS_BAD;
            end else begin
               launch_beat.cmd = stc_pkg::CMD_RMI;
            end
         end
         stc_pkg::OP_GET: begin
            launch_beat.index = (stc_pkg::IDX_W)'(req_payload.slot_index);
            if (!in_range) begin
               launch_beat.status = stc_pkg::STS_BAD;
            end else begin
               launch_beat.cmd = stc_pkg::CMD_GET;
            end
         end
         default: begin
         end
      endcase
   end

   // ---- commit on return ----
   assign next_ok = done_beat.next_link[0] &&
                    (done_beat.next_link[stc_pkg::HANDLE_BITS-1:1] <
                     (stc_pkg::HANDLE_BITS - 1)'(fill_ff));

   always_comb begin
      fill_in = fill_ff;
      head_in = head_ff;
      if (done_beat.valid) begin
         case (done_beat.cmd)
            stc_pkg::CMD_POP: begin
               head_in = next_ok ? (stc_pkg::LINK_W)'(done_beat.next_link)
                                 : stc_pkg::EMPTY_LINK;
            end
            stc_pkg::CMD_APPEND: begin
               head_in = stc_pkg::EMPTY_LINK;
               fill_in = fill_ff + 1'b1;
            end
            stc_pkg::CMD_RMV, stc_pkg::CMD_RMI: begin
               if (done_beat.done) begin
                  head_in = (stc_pkg::LINK_W)'({done_beat.index, 1'b1});
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---- result register and skid entry ----
   always_comb begin
      done_rsp.result_index = (stc_pkg::SLOT_W)'(done_beat.index);
      done_rsp.result_value = (stc_pkg::VALUE_W)'(done_beat.res_value);
      done_rsp.status       = done_beat.status;
   end

   assign rsp_fire = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (done_beat.valid) begin
         if (!rsp_valid_ff || rsp_fire) begin
            rsp_in       = done_rsp;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = done_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= stc_pkg::CTL_IDLE;
         fill_ff       <= '0;
         head_ff       <= stc_pkg::EMPTY_LINK;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         head_ff       <= head_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign fill_count  = fill_ff;

endmodule

/* hdl/slot_table_free_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_free_list: handle slot table with an embedded free list
// Top level: controller plus a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per operation (add, remove by value, remove by
//   index, get). rsp channel: exactly one result beat per request, in order.
//   A request is taken when req_valid is high and req_stall is low.
//   One operation is in flight at a time: req_stall stays high from the
//   request until its beat has passed the chain (8 cells of 32 slots) and
//   has been committed. Every operation walks the whole chain, since the
//   remove-by-value search visits the cells in slot order, lowest first.
//   Free-list head and fill count are committed as the beat leaves the
//   chain; the next request is decoded against the updated values.
//   A result held by rsp_stall sits in the output register; one more result
//   can complete into a skid entry, and req_stall stays high while that
//   entry is occupied.
//   Reset (synchronous): fill count zero, free list empty, no beats in the
//   chain, no result pending. The slot words are not cleared; only slots
//   below the fill count are ever read.
// ----------------------------------------------------------------------------
module slot_table_free_list (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  stc_pkg::stc_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output stc_pkg::stc_rsp_type rsp_payload
);

   // chain links: element 0 is the launch beat, the last one returns
   stc_pkg::stc_beat_type     chain_beat [stc_pkg::NUM_CELLS + 1];
   logic [stc_pkg::CNT_W-1:0] fill_count;

   stc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .launch_beat (chain_beat[0]),
      .fill_count  (fill_count),
      .done_beat   (chain_beat[stc_pkg::NUM_CELLS])
   );

   // cell k owns slots k*CELL_SLOTS .. k*CELL_SLOTS+CELL_SLOTS-1
   for (genvar k = 0; k < stc_pkg::NUM_CELLS; k++) begin : g_cell
      stc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_id    ((stc_pkg::CID_W)'(k)),
         .fill_count (fill_count),
         .up_beat    (chain_beat[k]),
         .down_beat  (chain_beat[k + 1])
      );
   end

endmodule

/* hdl/stc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_checker: port-level assertions for slot_table_free_list
// Watches the request and result channels; attached by bind.
// ----------------------------------------------------------------------------
module stc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input stc_pkg::stc_req_type req_payload,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input stc_pkg::stc_rsp_type rsp_payload
);

   // a held result beat does not move
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed while stalled");

   // one operation at a time: the cycle after a request beat is stalled
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in flight");

   // full and not-found carry neither an index nor a word
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == stc_pkg::STS_FULL ||
                    rsp_payload.status == stc_pkg::STS_NOT_FOUND)
      |-> rsp_payload.result_index == '0 && rsp_payload.result_value == '0)
      else $error("miss result carries data");

   // an odd slot word can only come from a free slot
   a_odd_word_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_value[0]
      |-> rsp_payload.status == stc_pkg::STS_FREE)
      else $error("odd slot word without free status");

endmodule

bind slot_table_free_list stc_checker u_stc_checker (.*);
